// File: design/pifht_pkg.sv
// Shared constants and control types for the point-in-figure hit test core.
package pifht_pkg;

   // Default configuration of the figure table and coordinate width.
   localparam int MAX_FIGURES_DEF = 32;
   localparam int COORD_BITS_DEF  = 20;

   // Fixed field widths.
   localparam int RADIUS_W = 19;
   localparam int KIND_W   = 2;
   localparam int POINT_W  = 16;
   localparam int FIGNUM_W = 6;

   // Request action codes.
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Figure kind codes; every other code is tested as a triangle.
   localparam logic [KIND_W-1:0] KIND_RECT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd1;

   // Controller states.
   typedef enum logic {
      CTL_IDLE,
      CTL_WALK
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_we;
      logic query_start;
      logic issue_valid;
      logic issue_last;
      logic issue_empty;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
      logic adv;
   } dp_status_type;

endpackage

// File: design/pifht_ctrl.sv
// Controller: request acceptance, figure count and the walk over the table.
module pifht_ctrl import pifht_pkg::*; #(
   parameter int MAX_FIGURES = MAX_FIGURES_DEF,
   parameter int AW = 5,
   parameter int CW = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  dp_status_type       status,
   output ctl_cmd_type         cmd,
   output logic [AW-1:0]       wr_addr,
   output logic [AW-1:0]       rd_addr,
   output logic [FIGNUM_W-1:0] issue_fig
);

   ctl_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          accept;

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   assign wr_addr   = count_ff[AW-1:0];
   assign rd_addr   = idx_ff;
   assign issue_fig = FIGNUM_W'(7'(idx_ff) + 7'd1);
   assign req_stall = (state_ff != CTL_IDLE) || status.busy;
   assign accept    = req_valid && !req_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         CTL_IDLE: begin
            if (accept && (req_action == ACTION_LOAD)) begin
               if (count_ff != CW'(MAX_FIGURES)) begin
                  cmd.load_we = 1'b1;
                  count_in    = count_ff + CW'(1);
               end
            end else if (accept) begin
               cmd.query_start = 1'b1;
               idx_in          = '0;
               state_in        = CTL_WALK;
            end
         end
         CTL_WALK: begin
            if (status.adv) begin
               cmd.issue_valid = 1'b1;
               if (count_ff == '0) begin
                  cmd.issue_empty = 1'b1;
                  cmd.issue_last  = 1'b1;
                  state_in        = CTL_IDLE;
               end else if (CW'(idx_ff) + CW'(1) == count_ff) begin
                  cmd.issue_last = 1'b1;
                  state_in       = CTL_IDLE;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

endmodule

// File: design/pifht_dp.sv
// Datapath: figure memory, hit test pipeline and result output register.
module pifht_dp import pifht_pkg::*; #(
   parameter int MAX_FIGURES = MAX_FIGURES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int AW = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_cmd_type                  cmd,
   output dp_status_type                status,
   input  logic [AW-1:0]                wr_addr,
   input  logic [AW-1:0]                rd_addr,
   input  logic [FIGNUM_W-1:0]          issue_fig,
   input  logic [KIND_W-1:0]            req_figure_kind,
   input  logic signed [COORD_BITS-1:0] req_corner_ax,
   input  logic signed [COORD_BITS-1:0] req_corner_ay,
   input  logic signed [COORD_BITS-1:0] req_corner_bx,
   input  logic signed [COORD_BITS-1:0] req_corner_by,
   input  logic signed [COORD_BITS-1:0] req_corner_cx,
   input  logic signed [COORD_BITS-1:0] req_corner_cy,
   input  logic [RADIUS_W-1:0]          req_radius,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [POINT_W-1:0]           rsp_point_number,
   output logic [FIGNUM_W-1:0]          rsp_figure_number,
   output logic                         rsp_contained,
   output logic                         rsp_last_result
);

   localparam int W    = COORD_BITS;
   localparam int DW   = W + 1;
   localparam int PW   = 2 * DW;
   localparam int XW   = PW + 1;
   localparam int SW   = XW + 2;
   localparam int RRW  = 2 * RADIUS_W;
   localparam int CMPW = (PW + 1 > RRW) ? PW + 1 : RRW;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic signed [W-1:0] ax;
      logic signed [W-1:0] ay;
      logic signed [W-1:0] bx;
      logic signed [W-1:0] by;
      logic signed [W-1:0] cx;
      logic signed [W-1:0] cy;
      logic [RADIUS_W-1:0] r;
   } entry_type;

   typedef struct packed {
      logic                v;
      logic                last;
      logic                empty;
      logic [FIGNUM_W-1:0] fig;
   } tag_type;

   entry_type mem [MAX_FIGURES];
   entry_type wentry, ent1_ff;
   tag_type   tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag0;
   logic      adv;

   logic signed [W-1:0]  px_ff, py_ff;
   logic [POINT_W-1:0]   pnum_ff;

   // Stage 2: differences.
   logic signed [DW-1:0] bax_ff, bay_ff, cax_ff, cay_ff, pax_ff, pay_ff;
   logic signed [DW-1:0] cbx_ff, cby_ff, pbx_ff, pby_ff;
   logic [KIND_W-1:0]    kind2_ff, kind3_ff, kind4_ff, kind5_ff;
   logic [RADIUS_W-1:0]  r2_ff;
   // Stage 3: products.
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff, m7_ff;
   logic signed [PW-1:0] sqx_ff, sqy_ff;
   logic [RRW-1:0]       rr3_ff, rr4_ff;
   logic                 rect3_ff, rect4_ff, rect5_ff;
   // Stage 4: cross products and circle distance.
   logic signed [XW-1:0] xt_ff, x1_ff, x2_ff, x3_ff;
   logic [PW:0]          dsum_ff;
   // Stage 5: areas and circle result.
   logic [XW-1:0]        at_ff, a1_ff, a2_ff, a3_ff;
   logic                 circ5_ff;

   logic                 hit5, tri_hit;
   logic [SW-1:0]        tri_sum;

   // Pending hit and output register.
   logic                 pend_v_ff, pend_v_in, pend_final_ff, pend_final_in;
   logic [FIGNUM_W-1:0]  pend_fig_ff, pend_fig_in;
   logic                 e_valid, e_cont, e_last;
   logic [FIGNUM_W-1:0]  e_fig;
   logic                 out_v_ff;
   logic [POINT_W-1:0]   out_pnum_ff;
   logic [FIGNUM_W-1:0]  out_fig_ff;
   logic                 out_cont_ff, out_last_ff;

   assign adv           = !out_v_ff || !rsp_stall;
   assign status.adv    = adv;
   assign status.busy   = tag1_ff.v || tag2_ff.v || tag3_ff.v || tag4_ff.v ||
                          tag5_ff.v || pend_v_ff;

   // Load entry; rectangle corners are ordered to min and max.
   always_comb begin
      wentry.kind = req_figure_kind;
      wentry.ax   = req_corner_ax;
      wentry.bx   = req_corner_bx;
      wentry.ay   = req_corner_ay;
      wentry.by   = req_corner_by;
      wentry.cx   = req_corner_cx;
      wentry.cy   = req_corner_cy;
      wentry.r    = req_radius;
      if (req_figure_kind == KIND_RECT) begin
         if (req_corner_ax > req_corner_bx) begin
            wentry.ax = req_corner_bx;
            wentry.bx = req_corner_ax;
         end
         if (req_corner_ay > req_corner_by) begin
            wentry.ay = req_corner_by;
            wentry.by = req_corner_ay;
         end
      end
   end

   // Figure memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         mem[wr_addr] <= wentry;
      end
      if (adv) begin
         ent1_ff <= mem[rd_addr];
      end
   end

   // Query point and running point number.
   always_ff @(posedge clock) begin
      if (reset) begin
         pnum_ff <= '0;
      end else if (cmd.query_start) begin
         pnum_ff <= pnum_ff + POINT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         px_ff <= req_point_x;
         py_ff <= req_point_y;
      end
   end

   // Pipeline tags.
   always_comb begin
      tag0.v     = cmd.issue_valid;
      tag0.last  = cmd.issue_last;
      tag0.empty = cmd.issue_empty;
      tag0.fig   = issue_fig;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else if (adv) begin
         tag1_ff <= tag0;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   // Arithmetic stages, all advancing together.
   always_ff @(posedge clock) begin
      if (adv) begin
         bax_ff   <= DW'(ent1_ff.bx) - DW'(ent1_ff.ax);
         bay_ff   <= DW'(ent1_ff.by) - DW'(ent1_ff.ay);
         cax_ff   <= DW'(ent1_ff.cx) - DW'(ent1_ff.ax);
         cay_ff   <= DW'(ent1_ff.cy) - DW'(ent1_ff.ay);
         pax_ff   <= DW'(px_ff) - DW'(ent1_ff.ax);
         pay_ff   <= DW'(py_ff) - DW'(ent1_ff.ay);
         cbx_ff   <= DW'(ent1_ff.cx) - DW'(ent1_ff.bx);
         cby_ff   <= DW'(ent1_ff.cy) - DW'(ent1_ff.by);
         pbx_ff   <= DW'(px_ff) - DW'(ent1_ff.bx);
         pby_ff   <= DW'(py_ff) - DW'(ent1_ff.by);
         kind2_ff <= ent1_ff.kind;
         r2_ff    <= ent1_ff.r;

         m0_ff    <= bax_ff * cay_ff;
         m1_ff    <= cax_ff * bay_ff;
         m2_ff    <= bax_ff * pay_ff;
         m3_ff    <= pax_ff * bay_ff;
         m4_ff    <= cbx_ff * pby_ff;
         m5_ff    <= pbx_ff * cby_ff;
         m6_ff    <= cax_ff * pay_ff;
         m7_ff    <= pax_ff * cay_ff;
         sqx_ff   <= pax_ff * pax_ff;
         sqy_ff   <= pay_ff * pay_ff;
         rr3_ff   <= RRW'(r2_ff) * RRW'(r2_ff);
         rect3_ff <= !pax_ff[DW-1] && (pax_ff != '0) && pbx_ff[DW-1] &&
                     !pay_ff[DW-1] && (pay_ff != '0) && pby_ff[DW-1];
         kind3_ff <= kind2_ff;

         xt_ff    <= XW'(m0_ff) - XW'(m1_ff);
         x1_ff    <= XW'(m2_ff) - XW'(m3_ff);
         x2_ff    <= XW'(m4_ff) - XW'(m5_ff);
         x3_ff    <= XW'(m6_ff) - XW'(m7_ff);
         dsum_ff  <= (PW + 1)'($unsigned(sqx_ff)) + (PW + 1)'($unsigned(sqy_ff));
         rr4_ff   <= rr3_ff;
         rect4_ff <= rect3_ff;
         kind4_ff <= kind3_ff;

         at_ff    <= xt_ff[XW-1] ? $unsigned(-xt_ff) : $unsigned(xt_ff);
         a1_ff    <= x1_ff[XW-1] ? $unsigned(-x1_ff) : $unsigned(x1_ff);
         a2_ff    <= x2_ff[XW-1] ? $unsigned(-x2_ff) : $unsigned(x2_ff);
         a3_ff    <= x3_ff[XW-1] ? $unsigned(-x3_ff) : $unsigned(x3_ff);
         circ5_ff <= CMPW'(dsum_ff) < CMPW'(rr4_ff);
         rect5_ff <= rect4_ff;
         kind5_ff <= kind4_ff;
      end
   end

   // Hit decision for the figure in the last stage.
   assign tri_sum = SW'(a1_ff) + SW'(a2_ff) + SW'(a3_ff);
   assign tri_hit = (SW'(at_ff) == tri_sum) && (a1_ff != '0) && (a2_ff != '0) &&
                    (a3_ff != '0);

   always_comb begin
      case (kind5_ff)
         KIND_RECT:   hit5 = rect5_ff;
         KIND_CIRCLE: hit5 = circ5_ff;
         default:     hit5 = tri_hit;
      endcase
      if (tag5_ff.empty) begin
         hit5 = 1'b0;
      end
   end

   // A hit waits in the pending register until it is known whether it is the last.
   always_comb begin
      pend_v_in     = pend_v_ff;
      pend_final_in = pend_final_ff;
      pend_fig_in   = pend_fig_ff;
      e_valid       = 1'b0;
      e_fig         = pend_fig_ff;
      e_cont        = 1'b1;
      e_last        = 1'b0;
      if (tag5_ff.v) begin
         if (hit5) begin
            e_valid       = pend_v_ff;
            pend_v_in     = 1'b1;
            pend_final_in = tag5_ff.last;
            pend_fig_in   = tag5_ff.fig;
         end else if (tag5_ff.last) begin
            e_valid   = 1'b1;
            e_last    = 1'b1;
            pend_v_in = 1'b0;
            if (!pend_v_ff) begin
               e_fig  = '0;
               e_cont = 1'b0;
            end
         end
      end else if (pend_v_ff && pend_final_ff) begin
         e_valid   = 1'b1;
         e_last    = 1'b1;
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else if (adv) begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= e_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pend_final_ff <= pend_final_in;
         pend_fig_ff   <= pend_fig_in;
         if (e_valid) begin
            out_pnum_ff <= pnum_ff;
            out_fig_ff  <= e_fig;
            out_cont_ff <= e_cont;
            out_last_ff <= e_last;
         end
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_point_number  = out_pnum_ff;
   assign rsp_figure_number = out_fig_ff;
   assign rsp_contained     = out_cont_ff;
   assign rsp_last_result   = out_last_ff;

endmodule

// File: design/point_in_figure_hit_test_core.sv
// Point-in-figure hit test core: a load transfer appends a rectangle, circle or
// triangle to a table of MAX_FIGURES entries (loads into a full table are dropped
// and give no result). A query transfer numbers the point and tests it against
// every stored figure in load order, one figure per cycle while the output is not
// stalled, through a five-stage pipeline fed from the figure memory's single read
// port. Each strictly containing figure gives one result; if none contains the
// point, one not-contained result with figure number zero is given; the final
// result of a query carries last_result. A new transfer is taken once the
// previous query's pipeline has drained.
module point_in_figure_hit_test_core import pifht_pkg::*; #(
   parameter int MAX_FIGURES = MAX_FIGURES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [KIND_W-1:0]            req_figure_kind,
   input  logic signed [COORD_BITS-1:0] req_corner_ax,
   input  logic signed [COORD_BITS-1:0] req_corner_ay,
   input  logic signed [COORD_BITS-1:0] req_corner_bx,
   input  logic signed [COORD_BITS-1:0] req_corner_by,
   input  logic signed [COORD_BITS-1:0] req_corner_cx,
   input  logic signed [COORD_BITS-1:0] req_corner_cy,
   input  logic [RADIUS_W-1:0]          req_radius,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [POINT_W-1:0]           rsp_point_number,
   output logic [FIGNUM_W-1:0]          rsp_figure_number,
   output logic                         rsp_contained,
   output logic                         rsp_last_result
);

   localparam int AW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
   localparam int CW = $clog2(MAX_FIGURES + 1);

   ctl_cmd_type         cmd;
   dp_status_type       status;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [FIGNUM_W-1:0] issue_fig;

   // Sequencing of loads and table walks.
   pifht_ctrl #(
      .MAX_FIGURES(MAX_FIGURES),
      .AW(AW),
      .CW(CW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .status(status),
      .cmd(cmd),
      .wr_addr(wr_addr),
      .rd_addr(rd_addr),
      .issue_fig(issue_fig)
   );

   // Figure storage, hit arithmetic and result register.
   pifht_dp #(
      .MAX_FIGURES(MAX_FIGURES),
      .COORD_BITS(COORD_BITS),
      .AW(AW)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .wr_addr(wr_addr),
      .rd_addr(rd_addr),
      .issue_fig(issue_fig),
      .req_figure_kind(req_figure_kind),
      .req_corner_ax(req_corner_ax),
      .req_corner_ay(req_corner_ay),
      .req_corner_bx(req_corner_bx),
      .req_corner_by(req_corner_by),
      .req_corner_cx(req_corner_cx),
      .req_corner_cy(req_corner_cy),
      .req_radius(req_radius),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_point_number(rsp_point_number),
      .rsp_figure_number(rsp_figure_number),
      .rsp_contained(rsp_contained),
      .rsp_last_result(rsp_last_result)
   );

`ifndef SYNTHESIS
   // A transfer is only taken when no earlier query is still in flight.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !status.busy)
      else $error("request taken while a query is in flight");

   // A not-contained result always closes its query.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_contained) |-> rsp_last_result)
      else $error("not-contained result without last flag");

   // A containing result names a real figure.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_contained) |-> (rsp_figure_number != '0))
      else $error("contained result with figure number zero");

   // The walk issues figures only while the result side can move.
   assert property (@(posedge clock) disable iff (reset)
      cmd.issue_valid |-> status.adv)
      else $error("figure issued during output stall");
`endif

endmodule
